// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the frame decoder modules.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge, idle while reset is held.
`define MFD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check on every rising edge, reset included.
`define MFD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/core/mfd_pkg.sv =====
// Package for the motor feedback frame decoder: constants, codes, item types.
// No dependencies; used by every module of the block.
package mfd_pkg;

    localparam int MOTOR_IDS       = 11;
    localparam int COUNTS_PER_TURN = 8192;
    localparam int HALF_TURN       = COUNTS_PER_TURN / 2;
    localparam int MASK_BITS       = 11;
    localparam int IDX_W           = (MOTOR_IDS > 1) ? $clog2(MOTOR_IDS) : 1;
    localparam int DELTA_W         = 18;
    localparam int PADDR_W         = 4;

    localparam logic [10:0] BASE_IDENTIFIER = 11'h201;
    localparam logic [3:0]  FRAME_BYTES     = 4'd8;
    localparam logic [7:0]  MAX_TEMP_RESET  = 8'd255;

    typedef enum logic {
        ACT_FRAME = 1'b0,
        ACT_CLEAR = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_MALFORMED = 2'd1,
        ST_UNKNOWN   = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        REG_REGISTERED = 2'd0,
        REG_DIRECTION  = 2'd1,
        REG_MAX_TEMP   = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [MASK_BITS-1:0] registered_mask;
        logic [MASK_BITS-1:0] direction_mask;
        logic [7:0]           max_temperature;
    } t_cfg;

    typedef struct packed {
        t_action     action;
        logic [10:0] identifier;
        logic        id_standard;
        logic        data_frame;
        logic [3:0]  byte_count;
        logic [63:0] payload;
    } t_item;

    typedef struct packed {
        t_status            status;
        logic [3:0]         motor_index;
        logic [15:0]        encoder_value;
        logic signed [31:0] position_count;
        logic signed [15:0] speed;
        logic signed [15:0] current_value;
        logic [7:0]         temperature;
        logic               fault;
    } t_result;

    function automatic logic mask_bit(logic [MASK_BITS-1:0] m, logic [IDX_W-1:0] i);
        logic b;
        b = 1'b0;
        if (int'(i) < MASK_BITS) begin
            b = m[i];
        end
        return b;
    endfunction

endpackage

// ===== rtl/core/motor_feedback_frame_decoder.sv =====
// Motor feedback frame decoder: top level with input and result registers.
// Depends on mfd_pkg, mfd_cfg_regs, mfd_decode and assert_macros.svh.
//
// Takes one item per cycle unless stalled: a CAN feedback frame (action 0) or
// a clear request for one motor entry (action 1); each gets exactly one result.
// Frames must be standard, 8-byte data frames from a registered motor in the
// identifier range 0x201 to 0x20B; the payload is unpacked big-endian, the
// encoder delta is unwrapped by one turn and added to a wrapping 32-bit count,
// and the direction mask negates position (wrapping) and speed (saturating).
// A temperature above max_temperature sets a sticky fault, cleared only by a
// clear request or reset. One item is taken per clock unless the output stalls
// with both registers full. Each item passes the input register and then the
// result register, around the read-modify-write of the per-motor state (held
// in flip-flops, cleared at reset). The input register acts as a skid stage,
// so an item is still taken while a result waits downstream, if the input
// register is empty.
// Write the configuration registers (0x0 registered mask, 0x4 direction mask,
// 0x8 temperature limit) only while no item is in flight.
module motor_feedback_frame_decoder (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mfd_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    // input channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_action,
    input  logic [10:0]                  i_identifier,
    input  logic                         i_id_standard,
    input  logic                         i_data_frame,
    input  logic [3:0]                   i_byte_count,
    input  logic [63:0]                  i_payload,
    // result channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [1:0]                   o_status,
    output logic [3:0]                   o_motor_index,
    output logic [15:0]                  o_encoder_value,
    output logic signed [31:0]           o_position_count,
    output logic signed [15:0]           o_speed,
    output logic signed [15:0]           o_current_value,
    output logic [7:0]                   o_temperature,
    output logic                         o_fault
);
    import mfd_pkg::*;
    `include "assert_macros.svh"

    t_cfg    cfg;
    t_item   r_in;
    logic    r_in_valid;
    logic    n_in_valid;
    t_result r_out;
    logic    r_out_valid;
    logic    n_out_valid;
    t_result result;
    logic    in_take;
    logic    adv;

    mfd_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    mfd_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // Advance the held item whenever the result register is free or draining.
    assign adv        = r_in_valid && (!r_out_valid || !i_out_stall);
    // Hold off the sender only when both stages are full and the output stalls.
    assign o_in_stall = r_in_valid && r_out_valid && i_out_stall;
    assign in_take    = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid  = in_take || (r_in_valid && !adv);
        n_out_valid = adv || (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers: capture the item on acceptance, the result on advance.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.action      <= t_action'(i_action);
            r_in.identifier  <= i_identifier;
            r_in.id_standard <= i_id_standard;
            r_in.data_frame  <= i_data_frame;
            r_in.byte_count  <= i_byte_count;
            r_in.payload     <= i_payload;
        end
        if (adv) begin
            r_out <= result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out.status;
    assign o_motor_index    = r_out.motor_index;
    assign o_encoder_value  = r_out.encoder_value;
    assign o_position_count = r_out.position_count;
    assign o_speed          = r_out.speed;
    assign o_current_value  = r_out.current_value;
    assign o_temperature    = r_out.temperature;
    assign o_fault          = r_out.fault;

    `MFD_ASSERT_ALWAYS(a_reset_empties, !i_rst_n |=> !o_out_valid && !r_in_valid, "stages not empty after reset")
    `MFD_ASSERT(a_stall_only_full, o_in_stall |-> r_in_valid && r_out_valid, "input stalled with a free stage")
    `MFD_ASSERT(a_reject_zeroed, o_out_valid && o_status != ST_OK |-> o_position_count == 0 && o_fault == 1'b0 && o_speed == 0, "rejected item carries data")
    `MFD_ASSERT(a_advance_loads, adv |=> o_out_valid, "advanced item not shown")

endmodule

// ===== rtl/core/mfd_cfg_regs.sv =====
// APB-style configuration registers of the frame decoder.
// Depends on mfd_pkg.
module mfd_cfg_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mfd_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output mfd_pkg::t_cfg                o_cfg
);
    import mfd_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx reg_sel;
    logic     wr_en;

    assign reg_sel = t_reg_idx'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.registered_mask <= '0;
            r_cfg.direction_mask  <= '0;
            r_cfg.max_temperature <= MAX_TEMP_RESET;
        end else if (wr_en) begin
            case (reg_sel)
                REG_REGISTERED: r_cfg.registered_mask <= pwdata[MASK_BITS-1:0];
                REG_DIRECTION:  r_cfg.direction_mask  <= pwdata[MASK_BITS-1:0];
                REG_MAX_TEMP:   r_cfg.max_temperature <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (reg_sel)
            REG_REGISTERED: prdata = 32'(r_cfg.registered_mask);
            REG_DIRECTION:  prdata = 32'(r_cfg.direction_mask);
            REG_MAX_TEMP:   prdata = 32'(r_cfg.max_temperature);
            default:        prdata = '0;
        endcase
    end

endmodule

// ===== rtl/core/mfd_decode.sv =====
// Per-motor tracking state and the combinational decode of one item.
// Depends on mfd_pkg and assert_macros.svh.
module mfd_decode (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  mfd_pkg::t_item  i_item,
    input  mfd_pkg::t_cfg   i_cfg,
    output mfd_pkg::t_result o_result
);
    import mfd_pkg::*;
    `include "assert_macros.svh"

    logic [15:0] r_prev   [MOTOR_IDS];
    logic        r_has    [MOTOR_IDS];
    logic [31:0] r_acc    [MOTOR_IDS];
    logic        r_fault  [MOTOR_IDS];

    logic [11:0]              id_diff;
    logic                     in_range;
    logic [IDX_W-1:0]         idx;
    logic                     well_formed;
    logic                     frame_ok;
    logic                     clear_ok;
    logic [15:0]              enc;
    logic [15:0]              prev_eff;
    logic [7:0]               temp;
    logic signed [DELTA_W-1:0] delta_raw;
    logic signed [DELTA_W-1:0] delta;
    logic [31:0]              acc_new;
    logic                     fault_new;
    logic                     reversed;
    logic signed [15:0]       spd_in;

    localparam logic signed [DELTA_W-1:0] HALF_S  = DELTA_W'(HALF_TURN);
    localparam logic signed [DELTA_W-1:0] TURN_S  = DELTA_W'(COUNTS_PER_TURN);

    always_comb begin
        id_diff     = {1'b0, i_item.identifier} - {1'b0, BASE_IDENTIFIER};
        in_range    = !id_diff[11] && (id_diff[10:0] < 11'(MOTOR_IDS));
        idx         = in_range ? id_diff[IDX_W-1:0] : '0;
        well_formed = i_item.id_standard && i_item.data_frame &&
                      (i_item.byte_count == FRAME_BYTES);
        frame_ok    = (i_item.action == ACT_FRAME) && well_formed && in_range &&
                      mask_bit(i_cfg.registered_mask, idx);
        clear_ok    = (i_item.action == ACT_CLEAR) && in_range;

        enc      = i_item.payload[63:48];
        spd_in   = signed'(i_item.payload[47:32]);
        temp     = i_item.payload[15:8];
        prev_eff = r_has[idx] ? r_prev[idx] : enc;

        // Unwrap the delta once by a full turn.
        delta_raw = signed'({2'b00, enc}) - signed'({2'b00, prev_eff});
        delta     = delta_raw;
        if (delta_raw > HALF_S) begin
            delta = delta_raw - TURN_S;
        end else if (delta_raw < -HALF_S) begin
            delta = delta_raw + TURN_S;
        end
        acc_new   = r_acc[idx] + {{(32-DELTA_W){delta[DELTA_W-1]}}, delta};
        fault_new = r_fault[idx] || (temp > i_cfg.max_temperature);
        reversed  = mask_bit(i_cfg.direction_mask, idx);

        o_result = '0;
        if (i_item.action == ACT_CLEAR) begin
            if (clear_ok) begin
                o_result.status      = ST_OK;
                o_result.motor_index = 4'(idx);
            end else begin
                o_result.status = ST_UNKNOWN;
            end
        end else if (!well_formed) begin
            o_result.status = ST_MALFORMED;
        end else if (!frame_ok) begin
            o_result.status = ST_UNKNOWN;
        end else begin
            o_result.status        = ST_OK;
            o_result.motor_index   = 4'(idx);
            o_result.encoder_value = enc;
            o_result.current_value = signed'(i_item.payload[31:16]);
            o_result.temperature   = temp;
            o_result.fault         = fault_new;
            if (reversed) begin
                o_result.position_count = signed'(32'd0 - acc_new);
                o_result.speed = (spd_in == 16'sh8000) ? 16'sh7FFF : -spd_in;
            end else begin
                o_result.position_count = signed'(acc_new);
                o_result.speed          = spd_in;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int m = 0; m < MOTOR_IDS; m++) begin
                r_prev[m]  <= '0;
                r_has[m]   <= 1'b0;
                r_acc[m]   <= '0;
                r_fault[m] <= 1'b0;
            end
        end else if (i_adv) begin
            if (clear_ok) begin
                r_prev[idx]  <= '0;
                r_has[idx]   <= 1'b0;
                r_acc[idx]   <= '0;
                r_fault[idx] <= 1'b0;
            end else if (frame_ok) begin
                r_prev[idx]  <= enc;
                r_has[idx]   <= 1'b1;
                r_acc[idx]   <= acc_new;
                r_fault[idx] <= fault_new;
            end
        end
    end

    `MFD_ASSERT(a_clear_drops_fault, i_adv && clear_ok |=> !r_fault[$past(idx)], "clear left fault set")
    `MFD_ASSERT(a_frame_seeds_entry, i_adv && frame_ok |=> r_has[$past(idx)], "frame did not seed entry")

endmodule

// ===== tb/tb.sv =====
// Self-checking bench for motor_feedback_frame_decoder: directed then random
// frames and clears, checked against a cycle-free decoder model held here.
// Depends on mfd_pkg and the RTL of the block only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mfd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    // Clock and reset: synchronous, active low.
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // Configuration port, parked idle until a write is issued.
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [PADDR_W-1:0]  paddr   = '0;
    logic [31:0]         pwdata  = '0;
    logic [31:0]         prdata;
    logic                pready;

    // Input channel: one packed item drives all payload ports.
    logic   in_valid = 1'b0;
    t_item  in_item  = '0;
    logic   o_in_stall;

    // Result channel.
    logic               out_stall = 1'b0;
    logic               o_out_valid;
    logic [1:0]         o_status;
    logic [3:0]         o_motor_index;
    logic [15:0]        o_encoder_value;
    logic signed [31:0] o_position_count;
    logic signed [15:0] o_speed;
    logic signed [15:0] o_current_value;
    logic [7:0]         o_temperature;
    logic               o_fault;

    motor_feedback_frame_decoder dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_in_valid       (in_valid),
        .o_in_stall       (o_in_stall),
        .i_action         (in_item.action),
        .i_identifier     (in_item.identifier),
        .i_id_standard    (in_item.id_standard),
        .i_data_frame     (in_item.data_frame),
        .i_byte_count     (in_item.byte_count),
        .i_payload        (in_item.payload),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (out_stall),
        .o_status         (o_status),
        .o_motor_index    (o_motor_index),
        .o_encoder_value  (o_encoder_value),
        .o_position_count (o_position_count),
        .o_speed          (o_speed),
        .o_current_value  (o_current_value),
        .o_temperature    (o_temperature),
        .o_fault          (o_fault)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Decoder model: configuration copy and per-motor tracking state.
    // ------------------------------------------------------------------
    logic [MASK_BITS-1:0] motor_registered = '0;
    logic [MASK_BITS-1:0] motor_reversed   = '0;
    logic [7:0]           temp_limit       = MAX_TEMP_RESET;

    logic [15:0] last_encoder [MOTOR_IDS] = '{default: '0};
    logic        seeded       [MOTOR_IDS] = '{default: 1'b0};
    logic [31:0] turn_count   [MOTOR_IDS] = '{default: '0};
    logic        overheated   [MOTOR_IDS] = '{default: 1'b0};

    // Encoder value last generated per motor, so random frames mostly move
    // by plausible steps instead of jumping across the whole range.
    logic [15:0] stim_encoder [MOTOR_IDS] = '{default: '0};

    t_item   pending_items[$];
    t_result expected_results[$];

    int mismatch_count = 0;
    int result_count   = 0;
    int cycle_count    = 0;

    // Work out the result of one accepted item and advance the model state.
    function automatic t_result predict_feedback(t_item it);
        t_result     r;
        logic        in_range;
        int          idx;
        logic [15:0] enc;
        int          delta;
        int          spd;
        logic [31:0] pos;
        r = '0;
        r.status = ST_OK;
        in_range = (it.identifier >= BASE_IDENTIFIER) &&
                   (int'(it.identifier) - int'(BASE_IDENTIFIER) < MOTOR_IDS);
        idx = in_range ? int'(it.identifier) - int'(BASE_IDENTIFIER) : 0;

        // Clear request: range only, format fields ignored.
        if (it.action == ACT_CLEAR) begin
            if (!in_range) begin
                r.status = ST_UNKNOWN;
                return r;
            end
            last_encoder[idx] = '0;
            seeded[idx]       = 1'b0;
            turn_count[idx]   = '0;
            overheated[idx]   = 1'b0;
            r.motor_index     = 4'(idx);
            return r;
        end

        // Format is checked before the identifier.
        if (!it.id_standard || !it.data_frame || it.byte_count != FRAME_BYTES) begin
            r.status = ST_MALFORMED;
            return r;
        end
        if (!in_range || !(idx < MASK_BITS && motor_registered[idx])) begin
            r.status = ST_UNKNOWN;
            return r;
        end

        enc = it.payload[63:48];
        // First sample after reset or clear seeds the history: no movement.
        if (!seeded[idx]) begin
            last_encoder[idx] = enc;
            seeded[idx]       = 1'b1;
        end
        delta = int'(enc) - int'(last_encoder[idx]);
        if (delta > HALF_TURN) begin
            delta -= COUNTS_PER_TURN;
        end else if (delta < -HALF_TURN) begin
            delta += COUNTS_PER_TURN;
        end
        last_encoder[idx] = enc;
        turn_count[idx]   = turn_count[idx] + 32'(delta);

        if (it.payload[15:8] > temp_limit) begin
            overheated[idx] = 1'b1;
        end

        pos = turn_count[idx];
        spd = $signed(it.payload[47:32]);
        // Reversed motor: wrap the position, saturate the speed.
        if (idx < MASK_BITS && motor_reversed[idx]) begin
            pos = 32'd0 - pos;
            spd = -spd;
            if (spd > 32767) begin
                spd = 32767;
            end
        end

        r.motor_index    = 4'(idx);
        r.encoder_value  = enc;
        r.position_count = pos;
        r.speed          = 16'(spd);
        r.current_value  = it.payload[31:16];
        r.temperature    = it.payload[15:8];
        r.fault          = overheated[idx];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Item builders.
    // ------------------------------------------------------------------
    function automatic t_item make_frame(logic [10:0] ident, logic [15:0] enc,
                                         logic [15:0] spd, logic [15:0] cur,
                                         logic [7:0] temp, logic [7:0] tail);
        t_item it;
        it.action      = ACT_FRAME;
        it.identifier  = ident;
        it.id_standard = 1'b1;
        it.data_frame  = 1'b1;
        it.byte_count  = FRAME_BYTES;
        it.payload     = {enc, spd, cur, temp, tail};
        return it;
    endfunction

    // Format fields of a clear are filled with noise: the block ignores them.
    function automatic t_item make_clear(logic [10:0] ident);
        t_item it;
        it.action      = ACT_CLEAR;
        it.identifier  = ident;
        it.id_standard = 1'($urandom);
        it.data_frame  = 1'($urandom);
        it.byte_count  = 4'($urandom);
        it.payload     = {$urandom, $urandom};
        return it;
    endfunction

    // Mostly well-formed frames with random content, some clears, and the
    // rest broken or fully random frames.
    function automatic t_item random_item();
        t_item       it;
        int          sel;
        int          idx;
        int          step;
        logic [15:0] enc;
        logic [7:0]  temp;
        sel = $urandom_range(0, 99);
        idx = $urandom_range(0, MOTOR_IDS - 1);

        if (sel < 8) begin
            if ($urandom_range(0, 4) == 0) begin
                it = make_clear(11'($urandom));
            end else begin
                it = make_clear(BASE_IDENTIFIER + 11'(idx));
            end
            return it;
        end

        // Encoder: small steps either side of the last value, sometimes a jump.
        if ($urandom_range(0, 3) == 0) begin
            enc = 16'($urandom);
        end else begin
            step = $urandom_range(0, 10000);
            step -= 5000;
            enc = stim_encoder[idx] + 16'(step);
        end
        stim_encoder[idx] = enc;

        // Temperature: hover around the limit, with the odd arbitrary value.
        if ($urandom_range(0, 2) == 0) begin
            temp = 8'($urandom);
        end else begin
            step = int'(temp_limit) + $urandom_range(0, 4);
            step -= 3;
            temp = (step < 0) ? 8'd0 : (step > 255) ? 8'd255 : 8'(step);
        end

        it = make_frame(BASE_IDENTIFIER + 11'(idx), enc, 16'($urandom),
                        16'($urandom), temp, 8'($urandom));
        if (sel < 85) begin
            return it;
        end

        // Noise: break one thing, or scramble the whole frame.
        case ($urandom_range(0, 4))
            0: it.id_standard = 1'b0;
            1: it.data_frame  = 1'b0;
            2: it.byte_count  = 4'($urandom_range(0, 15));
            3: it.identifier  = 11'($urandom);
            default: begin
                it.identifier  = 11'($urandom);
                it.id_standard = 1'($urandom);
                it.data_frame  = 1'($urandom);
                it.byte_count  = 4'($urandom);
                it.payload     = {$urandom, $urandom};
            end
        endcase
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Configuration writes: setup phase, then access phase.
    // ------------------------------------------------------------------
    task automatic write_reg(t_reg_idx r, logic [31:0] v);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (r)
            REG_REGISTERED: motor_registered = v[MASK_BITS-1:0];
            REG_DIRECTION:  motor_reversed   = v[MASK_BITS-1:0];
            REG_MAX_TEMP:   temp_limit       = v[7:0];
            default: ;
        endcase
    endtask

    task automatic set_motors(logic [10:0] reg_mask, logic [10:0] dir_mask,
                              logic [7:0] limit);
        write_reg(REG_REGISTERED, 32'(reg_mask));
        write_reg(REG_DIRECTION, 32'(dir_mask));
        write_reg(REG_MAX_TEMP, 32'(limit));
    endtask

    // Hold until every queued item is taken and every result has come back,
    // then allow the pipeline a margin to settle.
    task automatic wait_drained();
        while (pending_items.size() != 0 || in_valid || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic queue_random(int n);
        for (int k = 0; k < n; k++) begin
            pending_items.push_back(random_item());
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: present queued items in bursts with random gaps. The next item
    // is loaded only once the current one has been taken.
    // ------------------------------------------------------------------
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            // Item taken at this edge: predict its result now.
            if (in_valid && !o_in_stall) begin
                expected_results.push_back(predict_feedback(in_item));
            end
            if (!in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    in_item  <= pending_items.pop_front();
                    in_valid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 24);
                        case ($urandom_range(0, 3))
                            0:       gap_left = 0;
                            1, 2:    gap_left = $urandom_range(1, 3);
                            default: gap_left = $urandom_range(4, 12);
                        endcase
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each taken result with the oldest prediction, and
    // drive the result stall in stretches of differing density.
    // ------------------------------------------------------------------
    int stall_mode = 0;
    int stall_left = 0;

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch on result %0d: %s got 0x%0h, expected 0x%0h",
                 result_count, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
        if (got !== want) begin
            report_mismatch(what, got, want);
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with nothing outstanding", 32'(o_status), '0);
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", 32'(o_status), 32'(want.status));
                    check_field("motor_index", 32'(o_motor_index), 32'(want.motor_index));
                    check_field("encoder_value", 32'(o_encoder_value),
                                32'(want.encoder_value));
                    check_field("position_count", o_position_count, want.position_count);
                    check_field("speed", 32'(o_speed), 32'(want.speed));
                    check_field("current_value", 32'(o_current_value),
                                32'(want.current_value));
                    check_field("temperature", 32'(o_temperature), 32'(want.temperature));
                    check_field("fault", 32'(o_fault), 32'(want.fault));
                end
                result_count++;
            end

            // Pick a new stall pattern now and then: none, light, heavy, toggling.
            if (stall_left <= 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(4, 48);
            end
            stall_left--;
            case (stall_mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 3) == 0);
                2:       out_stall <= ($urandom_range(0, 3) != 0);
                default: out_stall <= ~out_stall;
            endcase
        end
    end

    // Watchdog: end a hung run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence: reset, directed cases, then random phases over several
    // register settings, extremes included.
    // ------------------------------------------------------------------
    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // All motors registered, only the last one reversed, limit mid-range.
        set_motors(11'h7FF, 11'h400, 8'd100);
        pending_items.push_back(make_clear(11'h201));
        // Seed sample: full-scale negative speed and current, temperature at limit.
        pending_items.push_back(make_frame(11'h201, 16'h0000, 16'h8000, 16'h8000,
                                           8'd100, 8'h00));
        // Half-turn step is kept; one count more wraps back.
        pending_items.push_back(make_frame(11'h201, 16'h1000, 16'h7FFF, 16'h7FFF,
                                           8'd101, 8'hFF));
        pending_items.push_back(make_frame(11'h201, 16'h2001, 16'h0000, 16'h0000,
                                           8'd0, 8'hA5));
        pending_items.push_back(make_frame(11'h201, 16'h1001, 16'h0001, 16'hFFFF,
                                           8'd50, 8'h5A));
        pending_items.push_back(make_frame(11'h201, 16'h0000, 16'hFFFF, 16'h0001,
                                           8'd50, 8'h00));
        pending_items.push_back(make_frame(11'h201, 16'hFFFF, 16'h1234, 16'h5678,
                                           8'd255, 8'hFF));
        // Reversed motor: most negative speed saturates.
        pending_items.push_back(make_frame(11'h20B, 16'h1234, 16'h8000, 16'h0000,
                                           8'd10, 8'h00));
        pending_items.push_back(make_frame(11'h20B, 16'h0000, 16'h0001, 16'h0000,
                                           8'd10, 8'h00));
        // Clear drops the fault; the next frame seeds again.
        pending_items.push_back(make_clear(11'h201));
        pending_items.push_back(make_frame(11'h201, 16'h0FFF, 16'h0100, 16'h0200,
                                           8'd20, 8'h00));
        // Malformed frames, one format fault each.
        pending_items.push_back(make_frame(11'h202, 16'h1111, 16'h1111, 16'h1111,
                                           8'd1, 8'd1));
        pending_items[$].id_standard = 1'b0;
        pending_items.push_back(make_frame(11'h202, 16'h2222, 16'h2222, 16'h2222,
                                           8'd2, 8'd2));
        pending_items[$].data_frame = 1'b0;
        pending_items.push_back(make_frame(11'h203, 16'h3333, 16'h3333, 16'h3333,
                                           8'd3, 8'd3));
        pending_items[$].byte_count = 4'd0;
        pending_items.push_back(make_frame(11'h7FF, 16'h4444, 16'h4444, 16'h4444,
                                           8'd4, 8'd4));
        pending_items[$].byte_count = 4'd15;
        pending_items.push_back(make_frame(11'h204, 16'h5555, 16'h5555, 16'h5555,
                                           8'd5, 8'd5));
        pending_items[$].byte_count = 4'd7;
        // Identifiers outside the motor range, then a clear of the last motor.
        pending_items.push_back(make_frame(11'h200, 16'h0, 16'h0, 16'h0, 8'd0, 8'd0));
        pending_items.push_back(make_frame(11'h20C, 16'h0, 16'h0, 16'h0, 8'd0, 8'd0));
        pending_items.push_back(make_frame(11'h7FF, 16'h0, 16'h0, 16'h0, 8'd0, 8'd0));
        pending_items.push_back(make_frame(11'h000, 16'h0, 16'h0, 16'h0, 8'd0, 8'd0));
        pending_items.push_back(make_clear(11'h200));
        pending_items.push_back(make_clear(11'h7FF));
        pending_items.push_back(make_clear(11'h20B));

        // Nothing registered: frames are refused, clears still succeed.
        wait_drained();
        set_motors(11'h000, 11'h7FF, 8'd1);
        pending_items.push_back(make_frame(11'h205, 16'h0100, 16'h0100, 16'h0100,
                                           8'd200, 8'd0));
        pending_items.push_back(make_clear(11'h205));

        // Random phases.
        wait_drained();
        set_motors(11'h7FF, 11'h000, 8'd255);
        queue_random(100);

        wait_drained();
        set_motors(11'($urandom), 11'h7FF, 8'd1);
        queue_random(100);

        wait_drained();
        set_motors(11'($urandom), 11'($urandom), 8'($urandom_range(1, 255)));
        queue_random(100);

        wait_drained();
        set_motors(11'h000, 11'($urandom), 8'($urandom_range(1, 255)));
        queue_random(30);

        wait_drained();
        set_motors(11'h7FF, 11'($urandom), 8'($urandom_range(1, 255)));
        queue_random(100);

        // Drain, then give any stray result time to show up.
        wait_drained();
        repeat (16) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/mfd_pkg.sv
rtl/core/mfd_cfg_regs.sv
rtl/core/mfd_decode.sv
rtl/core/motor_feedback_frame_decoder.sv
tb/tb.sv
